>>> hw/rtl/c8fd_pkg.sv
// shared types, codes and crc helper for the crc-8 frame deframer
// no dependencies; imported by every rtl file of the block but c8fd_ram
package c8fd_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND = 8'h55;
	localparam logic [7:0] CRC_POLY    = 8'h07;

	localparam int ID_W     = 6;
	localparam int LEN_W    = 7;
	localparam int BIDX_W   = 6;
	localparam int BYTE_W   = 8;
	localparam int HID_W    = 8;
	localparam int MASK_W   = 32;
	localparam int MASKIX_W = 5;

	typedef enum logic [2:0] {
		PH_HUNT0 = 3'd0,
		PH_HUNT1 = 3'd1,
		PH_ID    = 3'd2,
		PH_LEN   = 3'd3,
		PH_DATA  = 3'd4,
		PH_CHECK = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_READ = 2'd1,
		BK_SHOW = 2'd2
	} back_state_t;

	// one accepted frame waiting for delivery
	typedef struct packed {
		logic             bank;
		logic [ID_W-1:0]  id;
		logic [LEN_W-1:0] len;
	} desc_t;

	typedef struct packed {
		logic [ID_W-1:0]   msg_id;
		logic [LEN_W-1:0]  frame_len;
		logic [BIDX_W-1:0] byte_index;
		logic [BYTE_W-1:0] payload_byte;
		logic              has_data;
		logic              last;
	} beat_t;

	// crc-8, msb first, no reflection
	function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/c8fd_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module c8fd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hw/rtl/c8fd_front.sv
// front end: sync hunt, header parse, payload store writes and crc check
// depends on c8fd_pkg; pushes one descriptor per delivered frame
module c8fd_front import c8fd_pkg::*; #(
	parameter int MAX_PAYLOAD = 64,
	parameter int MSG_IDS     = 32,
	parameter int IDX_W       = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [BYTE_W-1:0]   in_byte,
	input  logic [MASK_W-1:0]   id_mask,
	input  logic                q_full,
	output logic                wr_en,
	output logic [IDX_W:0]      wr_addr,
	output logic [BYTE_W-1:0]   wr_data,
	output logic                push,
	output desc_t               push_desc
);

	phase_t            phase_q, phase_d;
	logic [HID_W-1:0]  held_id_q, held_id_d;
	logic [LEN_W-1:0]  held_len_q, held_len_d;
	logic [LEN_W-1:0]  fill_q, fill_d;
	logic [7:0]        crc_q, crc_d;
	logic              bank_q;
	logic              accept;
	logic              frame_ok;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	assign frame_ok = (crc_q == in_byte) && (held_id_q < HID_W'(MSG_IDS))
		&& id_mask[held_id_q[MASKIX_W-1:0]];

	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (phase_q)
				PH_HUNT1: begin
					if (in_byte == SYNC_SECOND) phase_d = PH_ID;
					else if (in_byte == SYNC_FIRST) phase_d = PH_HUNT1;
					else phase_d = PH_HUNT0;
				end
				PH_ID: phase_d = PH_LEN;
				PH_LEN: begin
					if (in_byte > BYTE_W'(MAX_PAYLOAD)) phase_d = PH_HUNT0;
					else if (in_byte == '0) phase_d = PH_CHECK;
					else phase_d = PH_DATA;
				end
				PH_DATA: begin
					if (fill_d >= held_len_q) phase_d = PH_CHECK;
				end
				PH_CHECK: phase_d = PH_HUNT0;
				default: phase_d = (in_byte == SYNC_FIRST) ? PH_HUNT1 : PH_HUNT0;
			endcase
		end
	end

	always_comb begin
		held_id_d  = held_id_q;
		held_len_d = held_len_q;
		fill_d     = fill_q;
		crc_d      = crc_q;
		wr_en      = 1'b0;
		push       = 1'b0;
		wr_addr    = {bank_q, fill_q[IDX_W-1:0]};
		wr_data    = in_byte;
		push_desc  = '{bank: bank_q, id: held_id_q[ID_W-1:0], len: held_len_q};
		if (phase_q == PH_DATA) begin
			fill_d = fill_q + LEN_W'(1);
		end
		if (accept) begin
			unique case (phase_q)
				PH_ID: begin
					held_id_d = in_byte;
					crc_d     = crc8_feed(8'h00, in_byte);
				end
				PH_LEN: begin
					fill_d     = '0;
					held_len_d = in_byte[LEN_W-1:0];
					crc_d      = crc8_feed(crc_q, in_byte);
				end
				PH_DATA: begin
					wr_en = 1'b1;
					crc_d = crc8_feed(crc_q, in_byte);
				end
				PH_CHECK: push = frame_ok;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT0;
			held_id_q  <= '0;
			held_len_q <= '0;
			fill_q     <= '0;
			crc_q      <= '0;
			bank_q     <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (accept) begin
				held_id_q  <= held_id_d;
				held_len_q <= held_len_d;
				fill_q     <= fill_d;
				crc_q      <= crc_d;
			end
			if (push) begin
				bank_q <= !bank_q;
			end
		end
	end

endmodule

>>> hw/rtl/c8fd_fifo.sv
// two-entry descriptor queue between front and back end
// depends on c8fd_pkg; each entry owns one payload bank
module c8fd_fifo import c8fd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	input  logic  pop,
	output logic  full,
	output logic  not_empty,
	output desc_t head
);

	desc_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			unique case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: ;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("descriptor pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("descriptor popped from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");

endmodule

>>> hw/rtl/c8fd_back.sv
// back end: reads a queued frame from the payload store and emits its beats
// depends on c8fd_pkg; one registered ram read per payload beat
module c8fd_back import c8fd_pkg::*; #(
	parameter int IDX_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  desc_t             head,
	output logic              pop,
	output logic [IDX_W:0]    rd_addr,
	input  logic [BYTE_W-1:0] rd_data,
	output logic              out_valid,
	input  logic              out_ready,
	output beat_t             out_beat
);

	back_state_t      state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	beat_t            beat_q;

	assign out_beat = beat_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) state_d = (head.len == '0) ? BK_SHOW : BK_READ;
			end
			BK_READ: state_d = BK_SHOW;
			BK_SHOW: begin
				if (out_ready) state_d = beat_q.last ? BK_IDLE : BK_READ;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		out_valid = (state_q == BK_SHOW);
		pop       = (state_q == BK_SHOW) && out_ready && beat_q.last;
		rd_addr   = {head.bank, (state_q == BK_SHOW) ? idx_q + IDX_W'(1) : idx_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_SHOW && out_ready) begin
				idx_q <= beat_q.last ? '0 : idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && q_valid && head.len == '0) begin
			beat_q <= '{msg_id: head.id, frame_len: '0, byte_index: '0,
				payload_byte: '0, has_data: 1'b0, last: 1'b1};
		end else if (state_q == BK_READ) begin
			beat_q <= '{msg_id: head.id, frame_len: head.len,
				byte_index: BIDX_W'(idx_q), payload_byte: rd_data, has_data: 1'b1,
				last: (LEN_W'(idx_q) + LEN_W'(1) == head.len)};
		end
	end

	a_show_has_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != BK_IDLE) |-> q_valid) else $error("emitting without a queued frame");
	a_held_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(beat_q)))
		else $error("stalled beat changed");
	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == BK_IDLE && idx_q == '0)) else $error("pop left emitter busy");

endmodule

>>> hw/rtl/crc8_frame_deframer_core.sv
// top level of the crc-8 frame deframer: mask register, front, queue, back, store
// depends on c8fd_pkg, c8fd_ram, c8fd_front, c8fd_fifo, c8fd_back
//
// channel   dir  handshake          content
// s_*       in   tvalid/tready      tdata[7:0] rx_byte
// m_*       out  tvalid/tready      tdata msg_id..payload_byte, tuser has_data, tlast
// cfg_*     in   cfg_we             cfg_wdata id_enable_mask
//
// one rx beat per cycle is taken while the descriptor queue has room
// each delivered payload beat takes one store read, then one shown beat held until m_tready
// the payload store has two banks; with both holding undelivered frames s_tready drops
// arst_n clears control state, the mask and the queue; the store is not cleared
module crc8_frame_deframer_core import c8fd_pkg::*; #(
	parameter int MAX_PAYLOAD = 64,
	parameter int MSG_IDS     = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [5:0] msg_id, [12:6] frame_len, [18:13] byte_index,
	                               // [26:19] payload_byte, [31:27] zero
	output logic        m_tuser,   // [0] has_data
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	localparam int IDX_W     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int RAM_DEPTH = 2 ** (IDX_W + 1);

	logic [MASK_W-1:0] mask_q;
	logic              wr_en;
	logic [IDX_W:0]    wr_addr;
	logic [BYTE_W-1:0] wr_data;
	logic [IDX_W:0]    rd_addr;
	logic [BYTE_W-1:0] rd_data;
	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_valid;
	desc_t             push_desc;
	desc_t             head;
	beat_t             beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_we) begin
			mask_q <= cfg_wdata;
		end
	end

	c8fd_front #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.MSG_IDS     (MSG_IDS),
		.IDX_W       (IDX_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.id_mask   (mask_q),
		.q_full    (q_full),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.push      (push),
		.push_desc (push_desc)
	);

	c8fd_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (RAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	c8fd_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (head)
	);

	c8fd_back #(
		.IDX_W (IDX_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.head      (head),
		.pop       (pop),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_beat  (beat)
	);

	assign m_tdata = {5'b0, beat.payload_byte, beat.byte_index, beat.frame_len, beat.msg_id};
	assign m_tuser = beat.has_data;
	assign m_tlast = beat.last;

endmodule
